// ===== src/oop_pkg.sv =====
package oop_pkg;

  localparam int MAX_DEPTH  = 8;
  localparam int LEVEL_W    = 3;
  localparam int INDEX_W    = 21;
  localparam int ADDR_W     = 22;
  localparam int DEPTH_W    = 4;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int CHILDREN_W = 3;

  localparam logic [CHILDREN_W-1:0] LAST_CHILD = '1;

  // Node moving through the level chain.
  typedef struct packed {
    logic               valid;
    logic [INDEX_W-1:0] idx;
    logic               occ;
  } tok_t;

  // One result item.
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [INDEX_W-1:0] index;
    logic [ADDR_W-1:0]  addr;
    logic               occ;
    logic               last;
  } res_t;

  // Start of a level in the flat buffer: 1 + 8 + ... + 8^(level-1).
  function automatic logic [ADDR_W-1:0] level_offset(input logic [LEVEL_W-1:0] level);
    logic [ADDR_W-1:0] off;
    logic [ADDR_W-1:0] size;
    off  = '0;
    size = ADDR_W'(1);
    for (int k = 0; k < MAX_DEPTH; k++) begin
      if (k < int'(level)) begin
        off  = off + size;
        size = size << CHILDREN_W;
      end
    end
    return off;
  endfunction

  // Index mask of a level: 3*level low bits set.
  function automatic logic [INDEX_W-1:0] index_mask(input logic [LEVEL_W-1:0] level);
    logic [INDEX_W-1:0] m;
    m = '0;
    for (int i = 0; i < INDEX_W; i++) begin
      if (i < CHILDREN_W * int'(level)) m[i] = 1'b1;
    end
    return m;
  endfunction

endpackage

// ===== src/oop_cell.sv =====
module oop_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        clear,
  input  logic                        advance,
  input  logic [oop_pkg::LEVEL_W-1:0] level,
  input  oop_pkg::tok_t               inj,
  input  oop_pkg::tok_t               src,
  output oop_pkg::tok_t               tok,
  output oop_pkg::res_t               res
);

  logic                        tok_valid;
  logic                        tok_valid_next;
  logic [oop_pkg::INDEX_W-1:0] tok_idx;
  logic [oop_pkg::INDEX_W-1:0] tok_idx_next;
  logic                        tok_occ;
  logic                        tok_occ_next;
  logic                        acc;
  logic                        acc_next;
  logic                        carry;

  always_comb begin
    carry = src.valid && (src.idx[oop_pkg::CHILDREN_W-1:0] == oop_pkg::LAST_CHILD);
    if (inj.valid) begin
      tok_valid_next = 1'b1;
      tok_idx_next   = inj.idx;
      tok_occ_next   = inj.occ;
    end else if (carry) begin
      // eighth child closes this node
      tok_valid_next = 1'b1;
      tok_idx_next   = src.idx >> oop_pkg::CHILDREN_W;
      tok_occ_next   = acc | src.occ;
    end else begin
      tok_valid_next = 1'b0;
      tok_idx_next   = tok_idx;
      tok_occ_next   = tok_occ;
    end
    if (src.valid) begin
      acc_next = carry ? 1'b0 : (acc | src.occ);
    end else begin
      acc_next = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
      acc       <= 1'b0;
    end else if (clear) begin
      tok_valid <= 1'b0;
      acc       <= 1'b0;
    end else if (advance) begin
      tok_valid <= tok_valid_next;
      acc       <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tok_idx <= tok_idx_next;
      tok_occ <= tok_occ_next;
    end
  end

  always_comb begin
    tok.valid = tok_valid;
    tok.idx   = tok_idx;
    tok.occ   = tok_occ;
    res.level = level;
    res.index = tok_idx;
    res.addr  = oop_pkg::level_offset(level) + {1'b0, tok_idx};
    res.occ   = tok_occ;
    res.last  = (level == '0) ||
                (tok_idx[oop_pkg::CHILDREN_W-1:0] != oop_pkg::LAST_CHILD);
  end

endmodule

// ===== src/oop_fifo.sv =====
module oop_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  oop_pkg::res_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          pop_valid,
  output oop_pkg::res_t pop_data
);

  oop_pkg::res_t                  slots [oop_pkg::FIFO_DEPTH];
  logic [oop_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [oop_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic [oop_pkg::FIFO_CNT_W-1:0] count;
  logic                           do_push;
  logic                           do_pop;

  assign full      = (count == oop_pkg::FIFO_CNT_W'(oop_pkg::FIFO_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule

// ===== src/octree_occupancy_pyramid.sv =====
// Octree occupancy pyramid. Leaf occupancy bits of a full octree enter in
// Morton order, one per input transfer. Each leaf is written out first, then,
// when it closes a group of eight siblings, its parent (occupied if any child
// is), and so on toward the root. Every result carries level, index within
// the level, flat buffer address (level offset plus index) and a run_last flag
// on the final result of the leaf. tree_depth (1..8, 0 acts as 1, larger acts
// as 8) sets the number of levels; writing it starts a new tree and is taken
// only while the level chain holds no node. While a write is offered, leaves
// are held off, so a write and a leaf never transfer in the same cycle.
// Flow: a transferred leaf's node is registered in its level cell, then
// pushed into the output queue, from which it is offered on the output;
// each parent follows its child as the node hops down a chain of one cell
// per level. The next leaf is taken in the cycle the last result of the
// current leaf leaves the chain, so leaves that close no group go at one
// per cycle while the output queue has room. A four-entry output queue
// parts the chain from the output stall; while it is full the chain holds.
// No clearing pass after reset.
module octree_occupancy_pyramid (
  input  logic                        clk,
  input  logic                        rst,
  // configuration write
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [oop_pkg::DEPTH_W-1:0] tree_depth,
  // leaf input
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        leaf_occupied,
  // node results
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [oop_pkg::LEVEL_W-1:0] node_level,
  output logic [oop_pkg::INDEX_W-1:0] node_index,
  output logic [oop_pkg::ADDR_W-1:0]  buffer_address,
  output logic                        node_occupied,
  output logic                        run_last
);

  localparam int N = oop_pkg::MAX_DEPTH;

  logic [oop_pkg::DEPTH_W-1:0] depth_reg;
  logic [oop_pkg::DEPTH_W-1:0] depth_eff;
  logic [oop_pkg::LEVEL_W-1:0] leaf_lvl;
  logic [oop_pkg::INDEX_W-1:0] leaf_mask;
  logic [oop_pkg::INDEX_W-1:0] leaf_count;
  logic [oop_pkg::INDEX_W-1:0] leaf_count_next;

  logic          cfg_write;
  logic          in_accept;
  logic          advance;
  logic          busy;
  logic          fifo_full;
  oop_pkg::res_t emit;
  oop_pkg::res_t head;

  oop_pkg::tok_t toks [N];
  oop_pkg::tok_t srcs [N];
  oop_pkg::tok_t injs [N];
  oop_pkg::res_t ress [N];

  // Clamp the written depth into the legal range; the register keeps raw bits.
  always_comb begin
    if (depth_reg == '0) begin
      depth_eff = oop_pkg::DEPTH_W'(1);
    end else if (depth_reg > oop_pkg::DEPTH_W'(N)) begin
      depth_eff = oop_pkg::DEPTH_W'(N);
    end else begin
      depth_eff = depth_reg;
    end
    leaf_lvl  = oop_pkg::LEVEL_W'(depth_eff - 1'b1);
    leaf_mask = oop_pkg::index_mask(leaf_lvl);
  end

  assign cfg_ready = !busy;
  assign cfg_write = cfg_valid && cfg_ready;

  // Hold the whole chain while the output queue has no room.
  assign advance   = !fifo_full;
  // Take a leaf when the chain is empty or its node retires this cycle;
  // hold leaves while a depth write is offered.
  assign in_stall  = !(advance && (!busy || emit.last)) || cfg_valid;
  assign in_accept = in_valid && !in_stall;

  assign leaf_count_next = (leaf_count + 1'b1) & leaf_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_reg  <= oop_pkg::DEPTH_W'(N);
      leaf_count <= '0;
    end else if (cfg_write) begin
      depth_reg  <= tree_depth;
      leaf_count <= '0;
    end else if (in_accept) begin
      leaf_count <= leaf_count_next;
    end
  end

  // Level chain: cell k holds the open node of level k and passes each
  // finished node to cell k-1.
  for (genvar k = 0; k < N; k++) begin : g_cell
    always_comb begin
      injs[k].valid = in_accept && (leaf_lvl == oop_pkg::LEVEL_W'(k));
      injs[k].idx   = leaf_count & leaf_mask;
      injs[k].occ   = leaf_occupied;
    end

    if (k == N - 1) begin : g_top
      assign srcs[k] = '0;
    end else begin : g_mid
      assign srcs[k] = toks[k+1];
    end

    oop_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .clear   (cfg_write),
      .advance (advance),
      .level   (oop_pkg::LEVEL_W'(k)),
      .inj     (injs[k]),
      .src     (srcs[k]),
      .tok     (toks[k]),
      .res     (ress[k])
    );
  end

  // At most one cell holds a node; merge its result.
  always_comb begin
    emit = '0;
    busy = 1'b0;
    for (int k = 0; k < N; k++) begin
      if (toks[k].valid) begin
        emit = emit | ress[k];
        busy = 1'b1;
      end
    end
  end

  oop_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (advance && busy),
    .push_data (emit),
    .full      (fifo_full),
    .pop       (!out_stall),
    .pop_valid (out_valid),
    .pop_data  (head)
  );

  assign node_level     = head.level;
  assign node_index     = head.index;
  assign buffer_address = head.addr;
  assign node_occupied  = head.occ;
  assign run_last       = head.last;

endmodule

// ===== src/oop_checker.sv =====
module oop_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        cfg_valid,
  input logic                        cfg_ready,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [oop_pkg::LEVEL_W-1:0] node_level,
  input logic [oop_pkg::INDEX_W-1:0] node_index,
  input logic [oop_pkg::ADDR_W-1:0]  buffer_address,
  input logic                        run_last
);

  logic out_xfer;
  assign out_xfer = out_valid && !out_stall;

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(node_index) &&
      $stable(buffer_address) && $stable(node_level) && $stable(run_last))
    else $error("stalled result changed");

  // A parent follows only after the eighth child of a non-root node.
  a_parent_follows: assert property (@(posedge clk) disable iff (rst)
    out_xfer && !run_last |-> node_level != '0 &&
      node_index[oop_pkg::CHILDREN_W-1:0] == oop_pkg::LAST_CHILD)
    else $error("non-final result does not close a sibling group");

  // Root is always the final result, at index and address zero.
  a_root: assert property (@(posedge clk) disable iff (rst)
    out_xfer && node_level == '0 |-> run_last && node_index == '0 &&
      buffer_address == '0)
    else $error("bad root result");

  // A depth write never shares its cycle with a leaf transfer.
  a_cfg_alone: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |-> in_stall)
    else $error("depth write taken beside a leaf");

  // Queue is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present after reset");

endmodule

bind octree_occupancy_pyramid oop_checker u_oop_checker (
  .clk            (clk),
  .rst            (rst),
  .cfg_valid      (cfg_valid),
  .cfg_ready      (cfg_ready),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .node_level     (node_level),
  .node_index     (node_index),
  .buffer_address (buffer_address),
  .run_last       (run_last)
);
